>>> rtl/gregorian_date_day_offset_assert.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst in the scope where it is used.
`ifndef GREGORIAN_DATE_DAY_OFFSET_ASSERT_SVH
`define GREGORIAN_DATE_DAY_OFFSET_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GDO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gdo_pkg.sv
package gdo_pkg;

  // Calendar limits
  localparam logic [13:0] YEAR_LIMIT = 14'd10000;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  // Days in years 0..9999
  localparam logic [21:0] DAYS_TOTAL = 22'd3652425;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  localparam logic [4:0] LEN_31 = 5'd31;
  localparam logic [4:0] LEN_30 = 5'd30;
  localparam logic [4:0] LEN_29 = 5'd29;
  localparam logic [4:0] LEN_28 = 5'd28;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_YW1,
    S_YW2,
    S_INIT,
    S_MSUM,
    S_ADD,
    S_BS_MID,
    S_BS_W1,
    S_BS_W2,
    S_BS_CMP,
    S_LO_W1,
    S_LO_W2,
    S_LO_SUB,
    S_MWALK,
    S_DONE
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_MSUM,
    OP_ADD,
    OP_ARG_MID,
    OP_BS_CMP,
    OP_ARG_LO,
    OP_LO_SUB,
    OP_MWALK,
    OP_OUT
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic start_oor;
    logic msum_done;
    logic range_bad;
    logic bs_done;
    logic mwalk_done;
  } dp_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
      MON_FEB: len = leap ? LEN_29 : LEN_28;
      default: len = LEN_31;
    endcase
    return len;
  endfunction

  // floor(v / 100) for v < 16384 by reciprocal multiply
  function automatic logic [7:0] div100(input logic [13:0] v);
    logic [26:0] p;
    p = {13'd0, v} * 27'd5243;
    return p[26:19];
  endfunction

endpackage

>>> rtl/gdo_year_unit.sv
module gdo_year_unit (
  input  logic        clk,
  input  logic [13:0] yr,
  output logic [21:0] dby,
  output logic        leap
);
  import gdo_pkg::*;

  logic [13:0] y1;
  logic [13:0] t1;
  logic [7:0]  qt;
  logic [7:0]  qy;
  logic        nz;
  logic [13:0] t_in;
  logic [13:0] leaps;
  logic [22:0] dby_sum;
  logic [13:0] hund;

  assign t_in = (yr == 14'd0) ? 14'd0 : yr - 14'd1;

  // Stage 1: quotients by 100 of y-1 and of y
  always_ff @(posedge clk) begin
    y1 <= yr;
    t1 <= t_in;
    qt <= div100(t_in);
    qy <= div100(yr);
    nz <= (yr != 14'd0);
  end

  // Stage 2: days before year, leap flag
  always_comb begin
    leaps   = nz ? ({2'd0, t1[13:2]} - {6'd0, qt} + {8'd0, qt[7:2]} + 14'd1) : 14'd0;
    dby_sum = ({9'd0, y1} * 23'd365) + {9'd0, leaps};
    hund    = 14'({6'd0, qy} * 14'd100);
  end

  always_ff @(posedge clk) begin
    dby  <= dby_sum[21:0];
    leap <= (y1[1:0] == 2'd0) && ((hund != y1) || (qy[1:0] == 2'd0));
  end

endmodule

>>> rtl/gdo_datapath.sv
module gdo_datapath (
  input  logic                clk,
  input  gdo_pkg::dp_op_t     op,
  input  logic [13:0]         start_year,
  input  logic [3:0]          start_month,
  input  logic [4:0]          start_day,
  input  logic signed [20:0]  day_offset,
  output gdo_pkg::dp_status_t status,
  output logic [13:0]         result_year,
  output logic [3:0]          result_month,
  output logic [4:0]          result_day,
  output logic                out_of_range
);
  import gdo_pkg::*;

  logic [13:0]        y;
  logic [3:0]         m;
  logic [4:0]         d;
  logic signed [20:0] off;
  logic [3:0]         cm;
  logic [3:0]         mi;
  logic [21:0]        n;
  logic [23:0]        r;
  logic [13:0]        lo;
  logic [13:0]        hi;
  logic [13:0]        mid_q;
  logic [13:0]        yr_arg;
  logic               oor;

  logic [21:0] dby;
  logic        leap;
  logic [3:0]  cm_cl;
  logic [4:0]  len_cm;
  logic [4:0]  len_mi;
  logic [4:0]  cd_cl;
  logic [23:0] r_sum;
  logic        range_bad;
  logic [14:0] mid_sum;
  logic [13:0] mid;

  gdo_year_unit u_year (
    .clk  (clk),
    .yr   (yr_arg),
    .dby  (dby),
    .leap (leap)
  );

  // Clamping and per-step arithmetic
  always_comb begin
    if (start_month < MON_JAN) begin
      cm_cl = MON_JAN;
    end else if (start_month > MON_DEC) begin
      cm_cl = MON_DEC;
    end else begin
      cm_cl = start_month;
    end
    len_cm = month_len(cm, leap);
    len_mi = month_len(mi, leap);
    if (d == 5'd0) begin
      cd_cl = 5'd1;
    end else if (d > len_cm) begin
      cd_cl = len_cm;
    end else begin
      cd_cl = d;
    end
    r_sum     = {2'b00, n} + {{3{off[20]}}, off};
    range_bad = r_sum[23] || (r_sum[22:0] >= {1'b0, DAYS_TOTAL});
    mid_sum   = {1'b0, lo} + {1'b0, hi} + 15'd1;
    mid       = mid_sum[14:1];
  end

  assign status.start_oor  = oor;
  assign status.msum_done  = (mi >= cm);
  assign status.range_bad  = range_bad;
  assign status.bs_done    = (lo >= hi);
  assign status.mwalk_done = (cm >= MON_DEC) || (r[22:0] < {18'd0, len_cm});

  // Working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        y      <= start_year;
        m      <= start_month;
        d      <= start_day;
        off    <= day_offset;
        cm     <= cm_cl;
        yr_arg <= start_year;
        oor    <= (start_year >= YEAR_LIMIT);
      end
      OP_INIT: begin
        n  <= dby + {17'd0, cd_cl} - 22'd1;
        mi <= MON_JAN;
      end
      OP_MSUM: begin
        n  <= n + {17'd0, len_mi};
        mi <= mi + 4'd1;
      end
      OP_ADD: begin
        r   <= r_sum;
        lo  <= 14'd0;
        hi  <= YEAR_MAX;
        oor <= range_bad;
      end
      OP_ARG_MID: begin
        mid_q  <= mid;
        yr_arg <= mid;
      end
      OP_BS_CMP: begin
        if (dby <= r[21:0]) begin
          lo <= mid_q;
        end else begin
          hi <= mid_q - 14'd1;
        end
      end
      OP_ARG_LO: begin
        yr_arg <= lo;
      end
      OP_LO_SUB: begin
        r  <= r - {2'b00, dby};
        cm <= MON_JAN;
      end
      OP_MWALK: begin
        r  <= r - {19'd0, len_cm};
        cm <= cm + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      out_of_range <= oor;
      if (oor) begin
        result_year  <= y;
        result_month <= m;
        result_day   <= d;
      end else begin
        result_year  <= lo;
        result_month <= cm;
        result_day   <= r[4:0] + 5'd1;
      end
    end
  end

endmodule

>>> rtl/gdo_controller.sv
module gdo_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_stall,
  input  gdo_pkg::dp_status_t status,
  output gdo_pkg::dp_op_t     op,
  output logic                in_stall,
  output logic                out_valid
);
  import gdo_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and datapath op
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_YW1;
        end
      end
      S_YW1: begin
        state_next = status.start_oor ? S_DONE : S_YW2;
      end
      S_YW2: begin
        state_next = S_INIT;
      end
      S_INIT: begin
        op         = OP_INIT;
        state_next = S_MSUM;
      end
      S_MSUM: begin
        if (status.msum_done) begin
          state_next = S_ADD;
        end else begin
          op = OP_MSUM;
        end
      end
      S_ADD: begin
        op         = OP_ADD;
        state_next = status.range_bad ? S_DONE : S_BS_MID;
      end
      S_BS_MID: begin
        if (status.bs_done) begin
          op         = OP_ARG_LO;
          state_next = S_LO_W1;
        end else begin
          op         = OP_ARG_MID;
          state_next = S_BS_W1;
        end
      end
      S_BS_W1: begin
        state_next = S_BS_W2;
      end
      S_BS_W2: begin
        state_next = S_BS_CMP;
      end
      S_BS_CMP: begin
        op         = OP_BS_CMP;
        state_next = S_BS_MID;
      end
      S_LO_W1: begin
        state_next = S_LO_W2;
      end
      S_LO_W2: begin
        state_next = S_LO_SUB;
      end
      S_LO_SUB: begin
        op         = OP_LO_SUB;
        state_next = S_MWALK;
      end
      S_MWALK: begin
        if (status.mwalk_done) begin
          state_next = S_DONE;
        end else begin
          op = OP_MWALK;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register fills on OP_OUT, empties when taken
  always_comb begin
    if (op == OP_OUT) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

>>> rtl/gregorian_date_day_offset.sv
// Work from accept to result: a start year above 9999 skips all steps; a result that
// leaves the calendar ends the item after the month sum of the start date and the add;
// otherwise the month sum, a 13- or 14-step binary search on the year through the
// two-stage year unit, then a month walk of up to 11 steps.
// Throughput: one item at a time; the next item is taken once the result is in the
// output register, which holds it until taken. Reset (rst, synchronous) empties it.
module gregorian_date_day_offset (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [13:0]        start_year,
  input  logic [3:0]         start_month,
  input  logic [4:0]         start_day,
  input  logic signed [20:0] day_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [13:0]        result_year,
  output logic [3:0]         result_month,
  output logic [4:0]         result_day,
  output logic               out_of_range
);
  import gdo_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  gdo_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .op        (op),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  gdo_datapath u_dp (
    .clk          (clk),
    .op           (op),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .day_offset   (day_offset),
    .status       (status),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .out_of_range (out_of_range)
  );

endmodule

>>> rtl/gdo_checker.sv
`include "gregorian_date_day_offset_assert.svh"

module gdo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [13:0]        result_year,
  input logic [3:0]         result_month,
  input logic [4:0]         result_day,
  input logic               out_of_range
);

  // A stalled result stays offered
  `GDO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // One item in flight: input is stalled right after an accept
  `GDO_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken too early")

  // A computed date has a year of at most 9999, a month of 1 to 12 and a day of at least 1
  `GDO_ASSERT_NOW(a_date_legal, out_valid && !out_of_range,
    result_year <= 14'd9999 && result_month >= 4'd1 && result_month <= 4'd12 &&
    result_day >= 5'd1, "illegal result date")

endmodule

bind gregorian_date_day_offset gdo_checker u_gdo_checker (.*);
